// File: design/fcpi_pkg.sv
package fcpi_pkg;

	// Angle format is Q4.ANGLE_FRAC_BITS radians.
	localparam int ANGLE_FRAC_BITS = 16;
	localparam int ANG_W = ANGLE_FRAC_BITS + 4;
	localparam int AXIS_W = 16;
	localparam int AXIS_FRAC = 14;
	localparam int POS_W = 32;
	localparam int UNIT_W = 12;

	// Serial multiplier operands and product.
	localparam int MUL_W = 35;
	localparam int PROD_W = 2 * MUL_W;
	localparam int MUL_CNT_W = $clog2(MUL_W);
	localparam int M100_IN_W = 34;
	localparam int M100_OUT_W = M100_IN_W + 7;

	// CORDIC datapath.
	localparam int TRIG_W = 33;
	localparam int T_W = 36;
	localparam int CORDIC_ITERS = 30;
	localparam int ITER_W = $clog2(CORDIC_ITERS);
	localparam int TRIG_SHIFT = 30 - ANGLE_FRAC_BITS;

	// Conversion of an angle to game units by restoring division.
	localparam int DIV_W = 50;
	localparam int QUO_W = 14;
	localparam int QUO_CNT_W = $clog2(QUO_W);
	localparam int UNITS_SHIFT = 44 - ANGLE_FRAC_BITS;
	localparam int LOAD_SHIFT = 43 - ANGLE_FRAC_BITS;
	localparam int MOVE_SHIFT = 44;
	localparam int LOOK_SHIFT = 30;

	localparam longint PI_Q32 = 64'sd13493037704;
	localparam longint PI_Q30 = 64'sd3373259426;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint ONE_F = 64'sd1 <<< ANGLE_FRAC_BITS;
	localparam longint PI_F = (PI_Q32 + (64'sd1 <<< (31 - ANGLE_FRAC_BITS)))
		>>> (32 - ANGLE_FRAC_BITS);
	localparam longint YAW_STEP = (ONE_F + 5) / 10;
	localparam longint PITCH_STEP = (ONE_F + 10) / 20;
	localparam longint PITCH_LIMIT = (9 * ONE_F + 5) / 10;
	localparam longint CORDIC_K = 64'sh26DD3B6A;
	localparam longint AXIS_ONE = 64'sd1 <<< AXIS_FRAC;
	// Adding 8192 whole divisors keeps the dividend positive; it vanishes modulo 4096.
	localparam longint UNITS_BIAS = 64'sd8192 * 2 * PI_Q32;

	typedef enum logic {
		CFG_INVERT_YAW   = 1'b0,
		CFG_INVERT_PITCH = 1'b1
	} cfg_index_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_A,
		ST_MUL_B,
		ST_TRIG_YAW,
		ST_MOVE_XF,
		ST_MOVE_ZF,
		ST_MOVE_XS,
		ST_MOVE_ZS,
		ST_TRIG_PITCH,
		ST_LOOK_X,
		ST_LOOK_Z,
		ST_UNITS_PITCH,
		ST_UNITS_YAW,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                     action;
		logic signed [AXIS_W-1:0] axis_forward;
		logic signed [AXIS_W-1:0] axis_side;
		logic signed [AXIS_W-1:0] axis_vertical;
		logic signed [AXIS_W-1:0] axis_turn_yaw;
		logic signed [AXIS_W-1:0] axis_turn_pitch;
		logic signed [POS_W-1:0]  load_pos_x;
		logic signed [POS_W-1:0]  load_pos_y;
		logic signed [POS_W-1:0]  load_pos_z;
		logic [UNIT_W-1:0]        load_rot_pitch;
		logic [UNIT_W-1:0]        load_rot_yaw;
	} in_word_t;

	typedef struct packed {
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
		logic signed [POS_W-1:0] look_x;
		logic signed [POS_W-1:0] look_y;
		logic signed [POS_W-1:0] look_z;
		logic [UNIT_W-1:0]       rot_pitch_out;
		logic [UNIT_W-1:0]       rot_yaw_out;
	} out_word_t;

	function automatic logic [31:0] atan_entry(input logic [ITER_W-1:0] i);
		logic [31:0] r;
		unique case (i)
			5'd0:  r = 32'h3243F6A8;
			5'd1:  r = 32'h1DAC6705;
			5'd2:  r = 32'h0FADBAFC;
			5'd3:  r = 32'h07F56EA6;
			5'd4:  r = 32'h03FEAB76;
			5'd5:  r = 32'h01FFD55B;
			5'd6:  r = 32'h00FFFAAA;
			5'd7:  r = 32'h007FFF55;
			5'd8:  r = 32'h003FFFEA;
			5'd9:  r = 32'h001FFFFD;
			5'd10: r = 32'h000FFFFF;
			5'd11: r = 32'h0007FFFF;
			5'd12: r = 32'h0003FFFF;
			5'd13: r = 32'h0001FFFF;
			5'd14: r = 32'h0000FFFF;
			5'd15: r = 32'h00007FFF;
			5'd16: r = 32'h00003FFF;
			5'd17: r = 32'h00001FFF;
			5'd18: r = 32'h00000FFF;
			5'd19: r = 32'h000007FF;
			5'd20: r = 32'h000003FF;
			5'd21: r = 32'h000001FF;
			5'd22: r = 32'h000000FF;
			5'd23: r = 32'h0000007F;
			5'd24: r = 32'h0000003F;
			5'd25: r = 32'h0000001F;
			5'd26: r = 32'h0000000F;
			5'd27: r = 32'h00000008;
			5'd28: r = 32'h00000004;
			5'd29: r = 32'h00000002;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

	function automatic logic signed [AXIS_W-1:0] sat_axis(input logic signed [AXIS_W-1:0] a);
		logic signed [AXIS_W-1:0] r;
		r = a;
		if (a > AXIS_W'(AXIS_ONE))
			r = AXIS_W'(AXIS_ONE);
		if (a < -AXIS_W'(AXIS_ONE))
			r = -AXIS_W'(AXIS_ONE);
		return r;
	endfunction

	function automatic logic signed [M100_OUT_W-1:0] mul100(
		input logic signed [M100_IN_W-1:0] v);
		logic signed [M100_OUT_W-1:0] w;
		w = M100_OUT_W'(v);
		return (w <<< 6) + (w <<< 5) + (w <<< 2);
	endfunction

	// Arithmetic shift right that rounds toward zero.
	function automatic logic signed [PROD_W-1:0] trunc_shr(
		input logic signed [PROD_W-1:0] v, input int unsigned k);
		logic signed [PROD_W-1:0] bias;
		bias = (PROD_W'(1) <<< k) - PROD_W'(1);
		return v[PROD_W-1] ? ((v + bias) >>> k) : (v >>> k);
	endfunction

	function automatic logic signed [ANG_W-1:0] wrap_yaw(input logic signed [ANG_W-1:0] y);
		logic signed [ANG_W-1:0] r;
		r = y;
		if (r >= ANG_W'(PI_F))
			r = r - ANG_W'(2 * PI_F);
		if (r < -ANG_W'(PI_F))
			r = r + ANG_W'(2 * PI_F);
		return r;
	endfunction

endpackage

// File: design/fcpi_mul.sv
module fcpi_mul (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [fcpi_pkg::MUL_W-1:0]    a,
	input  logic signed [fcpi_pkg::MUL_W-1:0]    b,
	output logic                                 done,
	output logic signed [fcpi_pkg::PROD_W-1:0]   prod
);
	import fcpi_pkg::*;

	logic                     busy_q;
	logic                     done_q;
	logic [MUL_CNT_W-1:0]     cnt_q;
	logic signed [PROD_W-1:0] mcand_q;
	logic signed [PROD_W-1:0] acc_q;
	logic [MUL_W-1:0]         mplier_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + MUL_CNT_W'(1);
				if (cnt_q == MUL_CNT_W'(MUL_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The sign of the multiplier moves onto the multiplicand, so that only its
	// magnitude is shifted out, one bit a cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= b[MUL_W-1] ? -PROD_W'(a) : PROD_W'(a);
			mplier_q <= b[MUL_W-1] ? MUL_W'(-b) : MUL_W'(b);
			acc_q    <= '0;
		end else if (busy_q) begin
			if (mplier_q[0])
				acc_q <= acc_q + mcand_q;
			mcand_q  <= mcand_q <<< 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

// File: design/fcpi_cordic.sv
module fcpi_cordic (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [fcpi_pkg::ANG_W-1:0]    angle,
	output logic                                 done,
	output logic signed [fcpi_pkg::TRIG_W-1:0]   cos_val,
	output logic signed [fcpi_pkg::TRIG_W-1:0]   sin_val
);
	import fcpi_pkg::*;

	logic                     busy_q;
	logic                     done_q;
	logic [ITER_W-1:0]        i_q;
	logic signed [T_W-1:0]    t_q;
	logic signed [TRIG_W-1:0] x_q;
	logic signed [TRIG_W-1:0] y_q;
	logic                     neg_q;

	logic signed [T_W-1:0]    t0;
	logic signed [T_W-1:0]    t1;
	logic signed [T_W-1:0]    t2;
	logic                     neg0;
	logic signed [TRIG_W-1:0] x_sh;
	logic signed [TRIG_W-1:0] y_sh;
	logic signed [T_W-1:0]    atan_v;

	// Fold the angle into one turn and then into the right half plane.
	always_comb begin
		t0 = T_W'(angle) <<< TRIG_SHIFT;
		if (t0 > T_W'(PI_Q30))
			t1 = t0 - T_W'(2 * PI_Q30);
		else if (t0 < -T_W'(PI_Q30))
			t1 = t0 + T_W'(2 * PI_Q30);
		else
			t1 = t0;
		neg0 = 1'b0;
		t2   = t1;
		if (t1 > T_W'(HALF_PI_Q30)) begin
			t2   = t1 - T_W'(PI_Q30);
			neg0 = 1'b1;
		end else if (t1 < -T_W'(HALF_PI_Q30)) begin
			t2   = t1 + T_W'(PI_Q30);
			neg0 = 1'b1;
		end
		x_sh   = x_q >>> i_q;
		y_sh   = y_q >>> i_q;
		atan_v = T_W'(atan_entry(i_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + ITER_W'(1);
				if (i_q == ITER_W'(CORDIC_ITERS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			t_q   <= t2;
			x_q   <= TRIG_W'(CORDIC_K);
			y_q   <= '0;
			neg_q <= neg0;
		end else if (busy_q) begin
			if (t_q >= 0) begin
				x_q <= x_q - y_sh;
				y_q <= y_q + x_sh;
				t_q <= t_q - atan_v;
			end else begin
				x_q <= x_q + y_sh;
				y_q <= y_q - x_sh;
				t_q <= t_q + atan_v;
			end
		end
	end

	assign done    = done_q;
	assign cos_val = neg_q ? -x_q : x_q;
	assign sin_val = neg_q ? -y_q : y_q;

endmodule

// File: design/fcpi_div.sv
module fcpi_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [fcpi_pkg::ANG_W-1:0]   angle,
	output logic                                done,
	output logic [fcpi_pkg::UNIT_W-1:0]         units
);
	import fcpi_pkg::*;

	logic                    busy_q;
	logic                    done_q;
	logic [QUO_CNT_W-1:0]    cnt_q;
	logic [DIV_W-1:0]        rem_q;
	logic [DIV_W-1:0]        dsor_q;
	logic [QUO_W-1:0]        quo_q;
	logic signed [DIV_W-1:0] num;
	logic                    fits;

	always_comb begin
		num  = -(DIV_W'(angle) <<< UNITS_SHIFT) + DIV_W'(PI_Q32) + DIV_W'(UNITS_BIAS);
		fits = rem_q >= dsor_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + QUO_CNT_W'(1);
				if (cnt_q == QUO_CNT_W'(QUO_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// One quotient bit a cycle, most significant first.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= DIV_W'(num);
			dsor_q <= DIV_W'(2 * PI_Q32) << (QUO_W - 1);
			quo_q  <= '0;
		end else if (busy_q) begin
			if (fits)
				rem_q <= rem_q - dsor_q;
			quo_q  <= {quo_q[QUO_W-2:0], fits};
			dsor_q <= dsor_q >> 1;
		end
	end

	assign done  = done_q;
	assign units = quo_q[UNIT_W-1:0];

endmodule

// File: design/free_camera_pose_integrator.sv
// Free-fly camera pose integrator.
// Input words arrive on in_valid/in_ready/in_data. A load word sets the position
// and the yaw and pitch from game rotation units; a step word turns the camera by
// its turn axes and moves it by its movement axes rotated by the yaw. Every input
// word gives one output word on out_valid/out_ready/out_data: position, a look-at
// point 100 units ahead and the rotation in game units.
// The invert flags are written on cfg_valid/cfg_ready/cfg_index/cfg_data; the
// user must write them only while the block is idle, which the block does not
// enforce; cfg_ready is always high. One word is worked on at a time. All
// products but the scalings by 100 go through one bit-serial multiplier, sine
// and cosine through a 30-step CORDIC and the unit conversion through a 14-step
// divider. A new word is accepted only after the previous result has been written
// to the output register. If the receiver stalls, the result waits in the output
// register; the next word may still be taken and worked on, and holds in its last
// state until the output register is free.
// Reset clears the pose to zero, clears both invert flags and drops any result.
module free_camera_pose_integrator (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  fcpi_pkg::in_word_t     in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output fcpi_pkg::out_word_t    out_data,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  fcpi_pkg::cfg_index_t   cfg_index,
	input  logic                   cfg_data
);
	import fcpi_pkg::*;

	state_t state_q, state_d;
	logic   issued_q;
	logic   inv_yaw_q, inv_pitch_q;
	logic   out_valid_q;

	in_word_t  in_q;
	out_word_t out_q;

	logic signed [ANG_W-1:0]  yaw_q, pitch_q;
	logic [POS_W-1:0]         pos_x_q, pos_y_q, pos_z_q;
	logic signed [TRIG_W-1:0] cy_q, sy_q, cp_q;
	logic [POS_W-1:0]         look_x_q, look_y_q, look_z_q;
	logic [UNIT_W-1:0]        rot_p_q, rot_y_q;

	logic                     mul_start, mul_done;
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod;
	logic                     trig_start, trig_done;
	logic signed [ANG_W-1:0]  trig_angle;
	logic signed [TRIG_W-1:0] cos_val, sin_val;
	logic                     div_start, div_done;
	logic signed [ANG_W-1:0]  div_angle;
	logic [UNIT_W-1:0]        units;
	logic                     out_load;

	logic signed [AXIS_W-1:0]     af, as_ax, av, ay, ap;
	logic signed [M100_OUT_W-1:0] af100, as100;
	logic signed [PROD_W-1:0]     turn_full, load_full, move_full;
	logic signed [PROD_W-1:0]     look_p, look_full, vert_full, look_y_full;
	logic signed [ANG_W-1:0]      turn_delta, load_angle;
	logic signed [ANG_W:0]        pitch_sum;
	logic signed [ANG_W-1:0]      pitch_clamped;
	logic [POS_W-1:0]             move_inc, look_inc, vert_inc, look_y_inc;

	fcpi_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (prod)
	);

	fcpi_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (trig_start),
		.angle   (trig_angle),
		.done    (trig_done),
		.cos_val (cos_val),
		.sin_val (sin_val)
	);

	fcpi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.angle  (div_angle),
		.done   (div_done),
		.units  (units)
	);

	// Operand preparation and result scaling.
	always_comb begin
		af    = sat_axis(in_q.axis_forward);
		as_ax = sat_axis(in_q.axis_side);
		av    = sat_axis(in_q.axis_vertical);
		ay    = inv_yaw_q ? -sat_axis(in_q.axis_turn_yaw) : sat_axis(in_q.axis_turn_yaw);
		ap    = inv_pitch_q ? -sat_axis(in_q.axis_turn_pitch)
			: sat_axis(in_q.axis_turn_pitch);
		af100 = mul100(M100_IN_W'(af));
		as100 = mul100(M100_IN_W'(as_ax));

		turn_full  = (prod + PROD_W'(AXIS_ONE / 2)) >>> AXIS_FRAC;
		turn_delta = turn_full[ANG_W-1:0];
		load_full  = (prod + (PROD_W'(1) <<< (LOAD_SHIFT - 1))) >>> LOAD_SHIFT;
		load_angle = load_full[ANG_W-1:0];

		pitch_sum = (ANG_W + 1)'(pitch_q) + (ANG_W + 1)'(turn_delta);
		if (pitch_sum > (ANG_W + 1)'(PITCH_LIMIT))
			pitch_clamped = ANG_W'(PITCH_LIMIT);
		else if (pitch_sum < -(ANG_W + 1)'(PITCH_LIMIT))
			pitch_clamped = -ANG_W'(PITCH_LIMIT);
		else
			pitch_clamped = pitch_sum[ANG_W-1:0];

		move_full = trunc_shr(prod, MOVE_SHIFT);
		move_inc  = move_full[POS_W-1:0];
		look_p    = trunc_shr(prod, LOOK_SHIFT);
		look_full = trunc_shr(PROD_W'(mul100(look_p[M100_IN_W-1:0])), LOOK_SHIFT);
		look_inc  = look_full[POS_W-1:0];
		vert_full = trunc_shr(PROD_W'(mul100(M100_IN_W'(av))), AXIS_FRAC);
		vert_inc  = vert_full[POS_W-1:0];
		look_y_full = trunc_shr(PROD_W'(mul100(-M100_IN_W'(sin_val))), LOOK_SHIFT);
		look_y_inc  = look_y_full[POS_W-1:0];
	end

	// Sequencer: each working state starts its unit once and moves on when it is done.
	always_comb begin
		state_d    = state_q;
		mul_start  = 1'b0;
		trig_start = 1'b0;
		div_start  = 1'b0;
		mul_a      = '0;
		mul_b      = '0;
		trig_angle = yaw_q;
		div_angle  = pitch_q;
		out_load   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_d = ST_MUL_A;
			end
			ST_MUL_A: begin
				mul_start = !issued_q;
				if (in_q.action) begin
					mul_a = MUL_W'(PI_Q32);
					mul_b = MUL_W'(in_q.load_rot_pitch);
				end else begin
					mul_a = MUL_W'(ay);
					mul_b = MUL_W'(YAW_STEP);
				end
				if (mul_done)
					state_d = ST_MUL_B;
			end
			ST_MUL_B: begin
				mul_start = !issued_q;
				if (in_q.action) begin
					mul_a = MUL_W'(PI_Q32);
					mul_b = MUL_W'(in_q.load_rot_yaw);
				end else begin
					mul_a = MUL_W'(ap);
					mul_b = MUL_W'(PITCH_STEP);
				end
				if (mul_done)
					state_d = ST_TRIG_YAW;
			end
			ST_TRIG_YAW: begin
				trig_start = !issued_q;
				trig_angle = yaw_q;
				if (trig_done)
					state_d = in_q.action ? ST_TRIG_PITCH : ST_MOVE_XF;
			end
			ST_MOVE_XF: begin
				mul_start = !issued_q;
				mul_a     = -MUL_W'(cy_q);
				mul_b     = MUL_W'(af100);
				if (mul_done)
					state_d = ST_MOVE_ZF;
			end
			ST_MOVE_ZF: begin
				mul_start = !issued_q;
				mul_a     = -MUL_W'(sy_q);
				mul_b     = MUL_W'(af100);
				if (mul_done)
					state_d = ST_MOVE_XS;
			end
			ST_MOVE_XS: begin
				mul_start = !issued_q;
				mul_a     = -MUL_W'(sy_q);
				mul_b     = MUL_W'(as100);
				if (mul_done)
					state_d = ST_MOVE_ZS;
			end
			ST_MOVE_ZS: begin
				mul_start = !issued_q;
				mul_a     = MUL_W'(cy_q);
				mul_b     = MUL_W'(as100);
				if (mul_done)
					state_d = ST_TRIG_PITCH;
			end
			ST_TRIG_PITCH: begin
				trig_start = !issued_q;
				trig_angle = pitch_q;
				if (trig_done)
					state_d = ST_LOOK_X;
			end
			ST_LOOK_X: begin
				mul_start = !issued_q;
				mul_a     = -MUL_W'(sy_q);
				mul_b     = MUL_W'(cp_q);
				if (mul_done)
					state_d = ST_LOOK_Z;
			end
			ST_LOOK_Z: begin
				mul_start = !issued_q;
				mul_a     = MUL_W'(cy_q);
				mul_b     = MUL_W'(cp_q);
				if (mul_done)
					state_d = ST_UNITS_PITCH;
			end
			ST_UNITS_PITCH: begin
				div_start = !issued_q;
				div_angle = pitch_q;
				if (div_done)
					state_d = ST_UNITS_YAW;
			end
			ST_UNITS_YAW: begin
				div_start = !issued_q;
				div_angle = yaw_q;
				if (div_done)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issued_q    <= 1'b0;
			out_valid_q <= 1'b0;
			inv_yaw_q   <= 1'b0;
			inv_pitch_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mul_start || trig_start || div_start)
				issued_q <= 1'b1;
			else if (mul_done || trig_done || div_done)
				issued_q <= 1'b0;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_INVERT_YAW:   inv_yaw_q   <= cfg_data;
					CFG_INVERT_PITCH: inv_pitch_q <= cfg_data;
				endcase
			end
		end
	end

	// Pose state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_q   <= '0;
			pitch_q <= '0;
			pos_x_q <= '0;
			pos_y_q <= '0;
			pos_z_q <= '0;
		end else begin
			if (state_q == ST_IDLE && in_valid && in_data.action) begin
				pos_x_q <= in_data.load_pos_x;
				pos_y_q <= in_data.load_pos_y;
				pos_z_q <= in_data.load_pos_z;
			end
			if (state_q == ST_MUL_A && mul_done) begin
				if (in_q.action)
					pitch_q <= load_angle;
				else
					yaw_q <= yaw_q + turn_delta;
			end
			if (state_q == ST_MUL_B && mul_done) begin
				if (in_q.action) begin
					yaw_q <= wrap_yaw(-load_angle);
				end else begin
					pitch_q <= pitch_clamped;
					yaw_q   <= wrap_yaw(yaw_q);
				end
			end
			if ((state_q == ST_MOVE_XF || state_q == ST_MOVE_XS) && mul_done)
				pos_x_q <= pos_x_q + move_inc;
			if (state_q == ST_MOVE_ZF && mul_done)
				pos_z_q <= pos_z_q + move_inc;
			if (state_q == ST_MOVE_ZS && mul_done) begin
				pos_z_q <= pos_z_q + move_inc;
				pos_y_q <= pos_y_q + vert_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid)
			in_q <= in_data;
		if (state_q == ST_TRIG_YAW && trig_done) begin
			cy_q <= cos_val;
			sy_q <= sin_val;
		end
		if (state_q == ST_TRIG_PITCH && trig_done) begin
			cp_q     <= cos_val;
			look_y_q <= pos_y_q + look_y_inc;
		end
		if (state_q == ST_LOOK_X && mul_done)
			look_x_q <= pos_x_q + look_inc;
		if (state_q == ST_LOOK_Z && mul_done)
			look_z_q <= pos_z_q + look_inc;
		if (state_q == ST_UNITS_PITCH && div_done)
			rot_p_q <= units;
		if (state_q == ST_UNITS_YAW && div_done)
			rot_y_q <= units;
		if (out_load) begin
			out_q.pos_x         <= pos_x_q;
			out_q.pos_y         <= pos_y_q;
			out_q.pos_z         <= pos_z_q;
			out_q.look_x        <= look_x_q;
			out_q.look_y        <= look_y_q;
			out_q.look_z        <= look_z_q;
			out_q.rot_pitch_out <= rot_p_q;
			out_q.rot_yaw_out   <= rot_y_q;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Only one shared unit may finish at a time.
	a_one_unit_done: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({mul_done, trig_done, div_done}))
		else $error("two arithmetic units finished together");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_MUL_A))
		else $error("accepted word did not start the sequence");

	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && (!out_valid || out_ready)) |=> out_valid)
		else $error("finished result was not presented");

	// Between words the yaw always lies in its wrapped range.
	a_yaw_wrapped: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (yaw_q >= -ANG_W'(PI_F) && yaw_q < ANG_W'(PI_F)))
		else $error("yaw outside its wrapped range");

endmodule
